// ===== src/lcg_random_range_generator_assert.svh =====
// Assertion macros for the range generator
`ifndef LCG_RANDOM_RANGE_GENERATOR_ASSERT_SVH
`define LCG_RANDOM_RANGE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define LRRG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrrg assertion failed");
`define LRRG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrrg assertion failed");
`else
`define LRRG_ASSERT_IMP(lbl, ante, cons)
`define LRRG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/lrrg_pkg.sv =====
`default_nettype none
package lrrg_pkg;

	localparam logic [63:0] LCG_INIT = 64'h1234_5678_9ABC_DEF0;
	localparam logic [31:0] LCG_MULT_LO = 32'h4C95_7F2D;
	localparam logic [31:0] LCG_MULT_HI = 32'h5851_F42D;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// classified request between front and back
	typedef struct packed {
		logic signed [63:0] lo;
		logic [63:0]        span;
		logic               draw;
	} req_t;

endpackage
`default_nettype wire

// ===== src/lrrg_front.sv =====
`default_nettype none
module lrrg_front
	import lrrg_pkg::*;
(
	input  wire logic signed [63:0] lower_bound,
	input  wire logic signed [63:0] upper_bound,
	output      req_t               req
);

	always_comb begin
		req.lo = lower_bound;
		req.span = upper_bound - lower_bound + 64'd1;
		req.draw = (lower_bound < upper_bound);
	end

endmodule
`default_nettype wire

// ===== src/lrrg_queue.sv =====
`default_nettype none
`include "lcg_random_range_generator_assert.svh"
module lrrg_queue
	import lrrg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_data,
	output      logic full,
	input  wire logic pop,
	output      logic not_empty,
	output      req_t pop_data
);

	req_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= push_data;
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`LRRG_ASSERT_IMP(a_no_push_full, full, !push)
	`LRRG_ASSERT_IMP(a_no_pop_empty, !not_empty, !pop)

endmodule
`default_nettype wire

// ===== src/lrrg_back.sv =====
`default_nettype none
`include "lcg_random_range_generator_assert.svh"
module lrrg_back
	import lrrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [63:0] cfg_data,
	input  wire logic        q_valid,
	output      logic        q_ready,
	input  wire req_t        q_data,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [95:0] m_tdata,  // random_value[63:0], raw_word[95:64]
	output      logic        m_tuser   // drew
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_DIV, ST_DONE
	} st_t;

	st_t                st_q;
	logic [63:0]        gen_q;
	logic signed [63:0] lo_q;
	logic [63:0]        span_q;
	logic               draw_q;
	logic [63:0]        mul_q;
	logic [63:0]        lowp_q;
	logic [31:0]        cross_q;
	logic [31:0]        rem_q;
	logic [4:0]         cnt_q;
	logic               m_tvalid_q;
	logic [63:0]        out_value_q;
	logic [31:0]        out_raw_q;
	logic               out_drew_q;

	logic        pop;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] raw;
	logic [32:0] shift;
	logic        ge;
	logic [32:0] nrem;
	logic [31:0] hi_sum;

	assign q_ready = (st_q == ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE);
	assign pop = q_valid && q_ready;
	assign raw = gen_q[63:32];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_raw_q, out_value_q};
	assign m_tuser = out_drew_q;

	always_comb begin
		case (st_q)
			ST_M1: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MULT_HI;
			end
			ST_M2: begin
				mul_a = gen_q[63:32];
				mul_b = LCG_MULT_LO;
			end
			default: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MULT_LO;
			end
		endcase
	end

	// one restoring step of raw mod span
	always_comb begin
		shift = {rem_q, raw[cnt_q]};
		ge = ({31'd0, shift} >= span_q);
		nrem = ge ? (shift - span_q[32:0]) : shift;
		hi_sum = lowp_q[63:32] + cross_q + mul_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			gen_q <= LCG_INIT;
			lo_q <= '0;
			span_q <= '0;
			draw_q <= 1'b0;
			mul_q <= '0;
			lowp_q <= '0;
			cross_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
			out_value_q <= '0;
			out_raw_q <= '0;
			out_drew_q <= 1'b0;
		end else begin
			mul_q <= mul_a * mul_b;
			if (st_q == ST_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				gen_q <= cfg_data;
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						lo_q <= q_data.lo;
						span_q <= q_data.span;
						draw_q <= q_data.draw;
						rem_q <= '0;
						st_q <= q_data.draw ? ST_M0 : ST_DONE;
					end
				end
				ST_M0: st_q <= ST_M1;
				ST_M1: begin
					lowp_q <= mul_q;
					st_q <= ST_M2;
				end
				ST_M2: begin
					cross_q <= mul_q[31:0];
					st_q <= ST_M3;
				end
				ST_M3: begin
					gen_q <= {hi_sum, lowp_q[31:0]} + 64'd1;
					cnt_q <= 5'd31;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= nrem[31:0];
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0)
						st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						out_value_q <= lo_q + {32'd0, rem_q};
						out_raw_q <= draw_q ? raw : 32'd0;
						out_drew_q <= draw_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`LRRG_ASSERT_NXT(a_rem_bound, st_q == ST_DIV, span_q == 64'd0 || 64'(rem_q) < span_q)
	`LRRG_ASSERT_IMP(a_nodraw_zero, st_q == ST_DONE && !draw_q, rem_q == 32'd0)
	`LRRG_ASSERT_NXT(a_div_start, st_q == ST_M3, st_q == ST_DIV && cnt_q == 5'd31)

endmodule
`default_nettype wire

// ===== src/lcg_random_range_generator.sv =====
// A drawing request passes the 32x32 multiply states M0 to M3 for the state update, then a
// 32-step restoring remainder unit, one bit per cycle; a request with an empty range goes
// straight to the result. The back end takes a new request only once it is idle again.
// A two-entry queue lets requests be taken while the back end works or the result waits.
// Reset (arst_n low, asynchronous): state = 0x123456789ABCDEF0, queue and output emptied.
`default_nettype none
module lcg_random_range_generator
	import lrrg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic [63:0]  cfg_data,   // seed_value
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [127:0] s_tdata,    // lower_bound[63:0], upper_bound[127:64]
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [95:0]  m_tdata,    // random_value[63:0], raw_word[95:64]
	output      logic         m_tuser     // drew
);

	req_t req;
	req_t q_data;
	logic q_full;
	logic q_valid;
	logic q_ready;

	assign s_tready = !q_full;

	lrrg_front u_front (
		.lower_bound ($signed(s_tdata[63:0])),
		.upper_bound ($signed(s_tdata[127:64])),
		.req         (req)
	);

	lrrg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_data (req),
		.full      (q_full),
		.pop       (q_valid && q_ready),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	lrrg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import lrrg_pkg::*;

	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LCG_MULT = {LCG_MULT_HI, LCG_MULT_LO};
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [63:0] value;
		logic [31:0] raw;
		logic        drew;
	} range_draw_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [63:0]  cfg_data;   // seed_value
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;    // lower_bound[63:0], upper_bound[127:64]
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;    // random_value[63:0], raw_word[95:64]
	logic         m_tuser;    // drew

	logic [63:0]  gen_state = LCG_INIT;
	range_draw_t  pending_draws[$];
	int           errors = 0;
	int           stall_cycles = 0;
	bit           tx_idle_en = 1'b1;
	bit           rx_idle_en = 1'b1;
	int           rx_gap = 0;
	int           rx_hold = 0;
	int           n_requests = 0;
	int           n_draws = 0;
	int           n_empty = 0;
	int           n_full = 0;
	int           n_seeds = 0;

	lcg_random_range_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic range_draw_t predict_draw(input logic [63:0] lo, input logic [63:0] hi);
		range_draw_t d;
		logic [63:0] span;
		logic [63:0] offs;
		if ($signed(lo) >= $signed(hi)) begin
			d.value = lo;
			d.raw   = 32'd0;
			d.drew  = 1'b0;
			return d;
		end
		gen_state = gen_state * LCG_MULT + 64'd1;
		d.raw  = gen_state[63:32];
		d.drew = 1'b1;
		span   = hi - lo + 64'd1;
		offs   = (span == 64'd0) ? {32'd0, d.raw} : ({32'd0, d.raw} % span);
		d.value = lo + offs;
		return d;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(input logic [63:0] lo, input logic [63:0] hi);
		s_tvalid <= 1'b1;
		s_tdata  <= {hi, lo};
		do @(posedge clk); while (!s_tready);
		pending_draws.push_back(predict_draw(lo, hi));
		n_requests++;
		if ($signed(lo) >= $signed(hi))
			n_empty++;
		else begin
			n_draws++;
			if (hi - lo + 64'd1 == 64'd0)
				n_full++;
		end
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_seed(input logic [63:0] seed);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_state = seed;
		n_seeds++;
	endtask

	task automatic random_bounds(output logic [63:0] lo, output logic [63:0] hi);
		lo = rand64();
		case ($urandom_range(0, 9))
			0, 1: hi = rand64();
			2: hi = lo - 64'($urandom_range(0, 3));
			3: begin
				lo = S64_MIN;
				hi = S64_MAX;
			end
			4: begin
				lo = S64_MIN + 64'($urandom_range(0, 7));
				hi = S64_MAX - 64'($urandom_range(0, 7));
			end
			5, 6: hi = lo + 64'($urandom_range(1, 1000));
			7: hi = lo + 64'hFFFF_FFF0 + 64'($urandom_range(0, 31));
			8: begin
				lo = {{33{lo[31]}}, lo[30:0]};
				hi = lo + 64'($urandom);
			end
			default: begin
				hi = rand64();
				lo[63] = 1'b1;
				hi[63] = 1'b0;
			end
		endcase
	endtask

	task automatic test_directed();
		logic [63:0] los[$];
		logic [63:0] his[$];
		los = '{64'd0, 64'd5, S64_MAX, S64_MIN, S64_MAX, S64_MIN, S64_MIN, 64'd0,
			-64'sd1, S64_MIN, S64_MAX - 64'd1, 64'd0, -64'sd100, S64_MIN, 64'd0,
			S64_MIN, 64'd0, 64'd0, -64'sd2147483648, S64_MIN + 64'd1, S64_MIN};
		his = '{64'd0, -64'sd5, S64_MIN, S64_MIN, S64_MAX, S64_MAX, S64_MAX, 64'd1,
			64'd0, S64_MIN + 64'd1, S64_MAX, 64'd9, 64'd100, 64'd0, S64_MAX,
			-64'sd1, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'd2147483647, S64_MAX,
			S64_MAX - 64'd1};
		foreach (los[i])
			send_request(los[i], his[i]);
		wait_drained();
	endtask

	task automatic test_seed_phases();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] seed;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: seed = 64'd0;
				1: seed = '1;
				2: seed = LCG_INIT;
				default: seed = rand64();
			endcase
			load_seed(seed);
			tx_idle_en = (phase != 2);
			rx_idle_en = (phase != 4);
			repeat (230) begin
				random_bounds(lo, hi);
				send_request(lo, hi);
			end
			wait_drained();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		logic [63:0] lo;
		logic [63:0] hi;
		tx_idle_en = 1'b0;
		rx_hold = 400;
		repeat (40) begin
			random_bounds(lo, hi);
			send_request(lo, hi);
		end
		// sender waits for the whole backlog
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_streaming();
		logic [63:0] lo;
		logic [63:0] hi;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_seed(rand64());
		repeat (200) begin
			random_bounds(lo, hi);
			send_request(lo, hi);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_seed_phases();
		test_backpressure();
		test_streaming();
		s_tvalid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
		$display("Covered %0d requests: %0d draws (%0d full-range), %0d empty ranges,",
			n_requests, n_draws, n_full, n_empty);
		$display("%0d seed loads, idle bursts on both sides and a long output hold-off.",
			n_seeds);
		if (errors == 0 && pending_draws.size() == 0)
			$display("** lcg_random_range_generator: PASSED **");
		else
			$display("** lcg_random_range_generator: FAILED **");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else if (rx_idle_en && $urandom_range(0, 15) == 0) begin
				m_tready <= 1'b0;
				rx_gap = $urandom_range(1, 19) - 1;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		range_draw_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_draws.size() == 0) begin
				$error("result with no request outstanding: random_value %0d",
					$signed(m_tdata[63:0]));
				errors++;
			end else begin
				want = pending_draws.pop_front();
				if (m_tdata[63:0] !== want.value) begin
					$error("random_value mismatch: expected %0d, got %0d",
						$signed(want.value), $signed(m_tdata[63:0]));
					errors++;
				end
				if (m_tdata[95:64] !== want.raw) begin
					$error("raw_word mismatch: expected %0h, got %0h", want.raw,
						m_tdata[95:64]);
					errors++;
				end
				if (m_tuser !== want.drew) begin
					$error("drew mismatch: expected %0b, got %0b", want.drew, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
			$display("** lcg_random_range_generator: FAILED **");
			$finish;
		end
	end

endmodule
